/* design/bvh_pkg.sv */
package bvh_pkg;

  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [31:0] NEG_INF = 32'hFF80_0000;

  localparam logic [1:0] MODE_CORNER = 2'd0;
  localparam logic [1:0] MODE_LINK   = 2'd1;
  localparam logic [1:0] MODE_REFIT  = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  typedef struct packed {
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;
  } box_t;

  typedef struct packed {
    logic        leaf;
    logic [10:0] a;
    logic [10:0] b;
  } link_t;

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // true when a < b as ieee singles, -0 equal to +0, nan compares false
  function automatic logic fless(input logic [31:0] a, input logic [31:0] b);
    logic r;
    r = 1'b0;
    if (!is_nan(a) && !is_nan(b)) begin
      if (!a[31] && !b[31]) r = a[30:0] < b[30:0];
      else if (a[31] && b[31]) r = a[30:0] > b[30:0];
      else if (a[31] && !b[31]) r = (a[30:0] != 31'd0) || (b[30:0] != 31'd0);
      else r = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] fmin(input logic [31:0] a, input logic [31:0] b);
    return fless(b, a) ? b : a;
  endfunction

  function automatic logic [31:0] fmax(input logic [31:0] a, input logic [31:0] b);
    return fless(a, b) ? b : a;
  endfunction

  function automatic box_t box_merge(input box_t p, input box_t q);
    box_t r;
    r.min_x = fmin(p.min_x, q.min_x);
    r.min_y = fmin(p.min_y, q.min_y);
    r.min_z = fmin(p.min_z, q.min_z);
    r.max_x = fmax(p.max_x, q.max_x);
    r.max_y = fmax(p.max_y, q.max_y);
    r.max_z = fmax(p.max_z, q.max_z);
    return r;
  endfunction

  function automatic box_t box_empty();
    box_t r;
    r.min_x = POS_INF;
    r.min_y = POS_INF;
    r.min_z = POS_INF;
    r.max_x = NEG_INF;
    r.max_y = NEG_INF;
    r.max_z = NEG_INF;
    return r;
  endfunction

endpackage

/* design/bvh_ram.sv */
module bvh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* design/bvh_bottom_up_refit_top.sv */
// channel   direction  ports
// in        input      in_valid/in_ready, mode, target_index, corner, coords, link
// out       output     out_valid/out_ready, box_min_*, box_max_*, status
// cfg       apb        psel/penable/pwrite/paddr/pwdata/prdata/pready
// load items write memory when taken; a read item passes S_RD for its memory read;
// one item is in flight at a time: in_ready stays low until its result is taken.
// refit walks min(node_count, MAX_NODES) nodes from the highest index down to 0; a
// leaf reads its triangles one by one, an interior node its two child boxes in turn.
// reset is synchronous on rst_n and clears control and node_count only; memories are
// undefined until written. the out register holds its result while out_ready is low.
module bvh_bottom_up_refit_top import bvh_pkg::*; #(
  parameter int MAX_TRIANGLES = 1024,
  parameter int MAX_NODES     = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [10:0] in_target_index,
  input  logic [1:0]  in_corner,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_coord_z,
  input  logic        in_is_leaf,
  input  logic [10:0] in_link_a,
  input  logic [10:0] in_link_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_box_min_x,
  output logic [31:0] out_box_min_y,
  output logic [31:0] out_box_min_z,
  output logic [31:0] out_box_max_x,
  output logic [31:0] out_box_max_y,
  output logic [31:0] out_box_max_z,
  output logic        out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNTW = $clog2(MAX_NODES + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_LINK  = 8'b0000_0100,
    S_LEAF  = 8'b0000_1000,
    S_LACC  = 8'b0001_0000,
    S_LEFT  = 8'b0010_0000,
    S_RIGHT = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [11:0] node_count_r;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {20'd0, node_count_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) node_count_r <= pwdata[11:0];
  end

  // memories: one per corner, links, boxes
  logic [2:0]      cw_we;
  logic [TW-1:0]   c_waddr, c_raddr;
  logic [95:0]     c_wdata;
  logic [95:0]     c_rdata [3];
  logic            l_we;
  logic [NW-1:0]   l_waddr, l_raddr;
  link_t           l_wdata, l_rdata;
  logic            b_we;
  logic [NW-1:0]   b_waddr, b_raddr;
  box_t            b_wdata, b_rdata;

  for (genvar g = 0; g < 3; g++) begin : g_corner
    bvh_ram #(.WIDTH(96), .DEPTH(MAX_TRIANGLES)) u_corner (
      .clk(clk), .we(cw_we[g]), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata[g]));
  end

  bvh_ram #(.WIDTH(23), .DEPTH(MAX_NODES)) u_links (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata));

  bvh_ram #(.WIDTH(192), .DEPTH(MAX_NODES)) u_boxes (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata));

  // walk registers
  logic [CNTW-1:0] node_r, node_nxt;
  link_t           link_r, link_nxt;
  logic [11:0]     tri_r, tri_nxt;
  logic [10:0]     left_r, left_nxt;
  box_t            acc_r, acc_nxt;
  logic            lvalid_r, lvalid_nxt;
  box_t            out_box_r, out_box_nxt;
  logic            out_status_r, out_status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            tri_ok_r, tri_ok_nxt;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  wire in_xfer = in_valid && in_ready;

  wire c_oor = (32'(in_target_index) >= 32'(MAX_TRIANGLES)) || (in_corner > 2'd2);
  wire n_oor = 32'(in_target_index) >= 32'(MAX_NODES);

  logic [CNTW-1:0] walk_len;
  assign walk_len = (32'(node_count_r) > 32'(MAX_NODES)) ? CNTW'(MAX_NODES)
                                                         : CNTW'(node_count_r);

  box_t tri_box;
  always_comb begin
    tri_box.min_x = fmin(c_rdata[0][95:64], fmin(c_rdata[1][95:64], c_rdata[2][95:64]));
    tri_box.min_y = fmin(c_rdata[0][63:32], fmin(c_rdata[1][63:32], c_rdata[2][63:32]));
    tri_box.min_z = fmin(c_rdata[0][31:0], fmin(c_rdata[1][31:0], c_rdata[2][31:0]));
    tri_box.max_x = fmax(c_rdata[0][95:64], fmax(c_rdata[1][95:64], c_rdata[2][95:64]));
    tri_box.max_y = fmax(c_rdata[0][63:32], fmax(c_rdata[1][63:32], c_rdata[2][63:32]));
    tri_box.max_z = fmax(c_rdata[0][31:0], fmax(c_rdata[1][31:0], c_rdata[2][31:0]));
  end

  logic [11:0] tri_end;
  assign tri_end = 12'(link_r.a) + 12'(link_r.b);

  always_comb begin
    state_nxt      = state_r;
    node_nxt       = node_r;
    link_nxt       = link_r;
    tri_nxt        = tri_r;
    left_nxt       = left_r;
    acc_nxt        = acc_r;
    lvalid_nxt     = lvalid_r;
    tri_ok_nxt     = 1'b0;
    out_box_nxt    = out_box_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    cw_we   = '0;
    c_waddr = TW'(in_target_index);
    c_wdata = {in_coord_x, in_coord_y, in_coord_z};
    c_raddr = TW'(tri_r);
    l_we    = 1'b0;
    l_waddr = NW'(in_target_index);
    l_wdata = '{leaf: in_is_leaf, a: in_link_a, b: in_link_b};
    l_raddr = NW'(node_r);
    b_we    = 1'b0;
    b_waddr = NW'(node_r);
    b_wdata = acc_r;
    b_raddr = NW'(in_target_index);
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_box_nxt    = '0;
          out_status_nxt = 1'b0;
          case (in_mode)
            MODE_CORNER: begin
              out_status_nxt = c_oor;
              if (!c_oor) cw_we = 3'b001 << in_corner;
              out_valid_nxt = 1'b1;
            end
            MODE_LINK: begin
              out_status_nxt = n_oor;
              l_we = !n_oor;
              out_valid_nxt = 1'b1;
            end
            MODE_REFIT: begin
              node_nxt = walk_len;
              state_nxt = S_DONE;
            end
            default: begin
              out_status_nxt = n_oor;
              if (n_oor) out_valid_nxt = 1'b1;
              else state_nxt = S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        out_box_nxt   = b_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_DONE: begin
        // next node, or finish
        if (node_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          node_nxt  = node_r - 1'b1;
          l_raddr   = NW'(node_r - 1'b1);
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        link_nxt = l_rdata;
        acc_nxt  = box_empty();
        tri_nxt  = 12'(l_rdata.a);
        if (l_rdata.leaf) begin
          state_nxt = S_LEAF;
        end else begin
          b_raddr   = NW'(l_rdata.a);
          left_nxt  = l_rdata.b;
          lvalid_nxt = 32'(l_rdata.a) < 32'(MAX_NODES);
          state_nxt = S_LEFT;
        end
      end
      S_LEAF: begin
        // issue corner read for tri_r or write the box
        if (tri_r >= tri_end) begin
          b_we      = 1'b1;
          state_nxt = S_DONE;
        end else begin
          tri_ok_nxt = 32'(tri_r) < 32'(MAX_TRIANGLES);
          tri_nxt    = tri_r + 1'b1;
          state_nxt  = S_LACC;
        end
      end
      S_LACC: begin
        if (tri_ok_r) acc_nxt = box_merge(acc_r, tri_box);
        state_nxt = S_LEAF;
      end
      S_LEFT: begin
        if (lvalid_r) acc_nxt = b_rdata;
        b_raddr    = NW'(left_r);
        lvalid_nxt = 32'(left_r) < 32'(MAX_NODES);
        state_nxt  = S_RIGHT;
      end
      S_RIGHT: begin
        if (lvalid_r) acc_nxt = box_merge(acc_r, b_rdata);
        state_nxt = S_LEAF;
        tri_nxt   = tri_end;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    node_r       <= node_nxt;
    link_r       <= link_nxt;
    tri_r        <= tri_nxt;
    left_r       <= left_nxt;
    acc_r        <= acc_nxt;
    lvalid_r     <= lvalid_nxt;
    tri_ok_r     <= tri_ok_nxt;
    out_box_r    <= out_box_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_box_min_x = out_box_r.min_x;
  assign out_box_min_y = out_box_r.min_y;
  assign out_box_min_z = out_box_r.min_z;
  assign out_box_max_x = out_box_r.max_x;
  assign out_box_max_y = out_box_r.max_y;
  assign out_box_max_z = out_box_r.max_z;
  assign out_status    = out_status_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_box_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    b_we |-> (state_r == S_LEAF)) else $error("box write outside walk");
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (out_valid && state_r == S_IDLE))
    else $error("read result missing");

endmodule

/* bench/bvh_bottom_up_refit_top_test.sv */
`timescale 1ns / 1ps

module bvh_bottom_up_refit_top_test;
  import bvh_pkg::*;

  localparam int NUM_TRIS  = 1024;
  localparam int NUM_NODES = 2048;
  localparam logic [1:0] ADDR_NODE_COUNT = 2'd0;

  typedef struct {
    logic [1:0]  mode;
    logic [10:0] idx;
    logic [1:0]  corner;
    logic [31:0] x, y, z;
    logic        leaf;
    logic [10:0] a, b;
  } item_t;

  typedef struct {
    box_t box;
    logic status;
  } result_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_mode;
  logic [10:0] in_target_index;
  logic [1:0]  in_corner;
  logic [31:0] in_coord_x, in_coord_y, in_coord_z;
  logic        in_is_leaf;
  logic [10:0] in_link_a, in_link_b;
  logic        out_valid, out_ready;
  logic [31:0] out_box_min_x, out_box_min_y, out_box_min_z;
  logic [31:0] out_box_max_x, out_box_max_y, out_box_max_z;
  logic        out_status;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;

  bvh_bottom_up_refit_top u_dut (.*);

  // shadow state of the block
  logic [31:0] tri_pos [NUM_TRIS][3][3];
  logic [2:0]  corner_mask [NUM_TRIS];
  link_t       link_store [NUM_NODES];
  box_t        box_store [NUM_NODES];
  bit          box_known [NUM_NODES];
  logic [11:0] node_count_m;

  result_t     expected_q[$];
  int          fail_count;
  int          send_idle, recv_stall;
  int          random_items;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  // ieee ordering, -0 equal to +0, nan never less
  function automatic bit f_less(logic [31:0] p, logic [31:0] q);
    logic signed [32:0] kp, kq;
    if ((p[30:23] == 8'hFF && p[22:0] != 0) || (q[30:23] == 8'hFF && q[22:0] != 0))
      return 1'b0;
    kp = p[31] ? -$signed({2'b00, p[30:0]}) : $signed({2'b00, p[30:0]});
    kq = q[31] ? -$signed({2'b00, q[30:0]}) : $signed({2'b00, q[30:0]});
    return kp < kq;
  endfunction

  function automatic logic [31:0] f_lo(logic [31:0] p, logic [31:0] q);
    return f_less(q, p) ? q : p;
  endfunction

  function automatic logic [31:0] f_hi(logic [31:0] p, logic [31:0] q);
    return f_less(p, q) ? q : p;
  endfunction

  function automatic logic [31:0] box_part(box_t bx, int c);
    logic [191:0] flat;
    flat = bx;
    return flat[191 - 32 * c -: 32];
  endfunction

  function automatic void refit_node(int n);
    logic [31:0] acc [6];
    logic [31:0] p0, p1, p2;
    int t;
    for (int c = 0; c < 6; c++) acc[c] = (c < 3) ? POS_INF : NEG_INF;
    if (link_store[n].leaf) begin
      for (int i = 0; i < link_store[n].b; i++) begin
        t = link_store[n].a + i;
        if (t < NUM_TRIS) begin
          for (int c = 0; c < 3; c++) begin
            p0 = tri_pos[t][0][c];
            p1 = tri_pos[t][1][c];
            p2 = tri_pos[t][2][c];
            acc[c]     = f_lo(acc[c], f_lo(p0, f_lo(p1, p2)));
            acc[c + 3] = f_hi(acc[c + 3], f_hi(p0, f_hi(p1, p2)));
          end
        end
      end
    end else begin
      for (int c = 0; c < 3; c++) begin
        acc[c]     = f_lo(box_part(box_store[link_store[n].a], c),
                          box_part(box_store[link_store[n].b], c));
        acc[c + 3] = f_hi(box_part(box_store[link_store[n].a], c + 3),
                          box_part(box_store[link_store[n].b], c + 3));
      end
    end
    box_store[n] = {acc[0], acc[1], acc[2], acc[3], acc[4], acc[5]};
    box_known[n] = 1'b1;
  endfunction

  // applies one accepted item to the shadow state and returns its response
  function automatic result_t apply_item(item_t it);
    result_t r;
    int n;
    r.box = '0;
    r.status = 1'b0;
    case (it.mode)
      MODE_CORNER: begin
        if (it.idx >= NUM_TRIS || it.corner > 2) begin
          r.status = 1'b1;
        end else begin
          tri_pos[it.idx][it.corner][0] = it.x;
          tri_pos[it.idx][it.corner][1] = it.y;
          tri_pos[it.idx][it.corner][2] = it.z;
          corner_mask[it.idx][it.corner] = 1'b1;
        end
      end
      MODE_LINK: begin
        link_store[it.idx] = '{leaf: it.leaf, a: it.a, b: it.b};
      end
      MODE_REFIT: begin
        n = (node_count_m > NUM_NODES) ? NUM_NODES : node_count_m;
        for (int k = n - 1; k >= 0; k--) refit_node(k);
      end
      default: begin
        r.box = box_store[it.idx];
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_box_min_x !== e.box.min_x) begin
          $error("box_min_x exp %h got %h", e.box.min_x, out_box_min_x); fail_count++;
        end
        if (out_box_min_y !== e.box.min_y) begin
          $error("box_min_y exp %h got %h", e.box.min_y, out_box_min_y); fail_count++;
        end
        if (out_box_min_z !== e.box.min_z) begin
          $error("box_min_z exp %h got %h", e.box.min_z, out_box_min_z); fail_count++;
        end
        if (out_box_max_x !== e.box.max_x) begin
          $error("box_max_x exp %h got %h", e.box.max_x, out_box_max_x); fail_count++;
        end
        if (out_box_max_y !== e.box.max_y) begin
          $error("box_max_y exp %h got %h", e.box.max_y, out_box_max_y); fail_count++;
        end
        if (out_box_max_z !== e.box.max_z) begin
          $error("box_max_z exp %h got %h", e.box.max_z, out_box_max_z); fail_count++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); fail_count++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return POS_INF;
      3: return NEG_INF;
      4: return {1'($urandom_range(1)), 8'($urandom_range(120, 134)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t rand_item(logic [1:0] mode);
    item_t it;
    it.mode = mode;
    it.idx = 11'($urandom);
    it.corner = 2'($urandom);
    it.x = rand_coord();
    it.y = rand_coord();
    it.z = rand_coord();
    it.leaf = 1'($urandom);
    it.a = 11'($urandom);
    it.b = 11'($urandom);
    return it;
  endfunction

  task automatic send_item(item_t it);
    result_t r;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= it.mode;
    in_target_index <= it.idx;
    in_corner       <= it.corner;
    in_coord_x      <= it.x;
    in_coord_y      <= it.y;
    in_coord_z      <= it.z;
    in_is_leaf      <= it.leaf;
    in_link_a       <= it.a;
    in_link_b       <= it.b;
    do @(posedge clk); while (!in_ready);
    r = apply_item(it);
    expected_q.insert(expected_q.size(), r);
    random_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_node_count(logic [11:0] v);
    wait_idle();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_NODE_COUNT; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    node_count_m = v;
  endtask

  task automatic send_corner(int t, int c);
    item_t it;
    it = rand_item(MODE_CORNER);
    it.idx = 11'(t);
    it.corner = 2'(c);
    send_item(it);
  endtask

  task automatic send_link(int n, bit leaf, int a, int b);
    item_t it;
    it = rand_item(MODE_LINK);
    it.idx = 11'(n);
    it.leaf = leaf;
    it.a = 11'(a);
    it.b = 11'(b);
    send_item(it);
  endtask

  task automatic send_read(int n);
    item_t it;
    it = rand_item(MODE_READ);
    it.idx = 11'(n);
    send_item(it);
  endtask

  function automatic bit leaf_ready(int first, int count);
    for (int i = 0; i < count; i++)
      if (first + i < NUM_TRIS && corner_mask[first + i] != 3'b111) return 1'b0;
    return 1'b1;
  endfunction

  // a link that refit of the first lim nodes may walk safely
  task automatic send_safe_link(int n, int lim);
    int a, b, r;
    if (n < lim - 1 && $urandom_range(1)) begin
      a = $urandom_range(n + 1, lim - 1);
      b = $urandom_range(n + 1, lim - 1);
      // child a at or below parent, or b at any node, may take its stored box
      r = $urandom_range(n);
      if ($urandom_range(5) == 0 && box_known[r]) a = r;
      r = $urandom_range(NUM_NODES - 1);
      if ($urandom_range(5) == 0 && box_known[r]) b = r;
      send_link(n, 1'b0, a, b);
    end else begin
      r = $urandom_range(49);
      if (r < 40) begin
        a = $urandom_range(63); b = $urandom_range(6);
      end else if (r < 49) begin
        a = $urandom_range(1000, 1023); b = $urandom_range(40);
      end else begin
        a = $urandom_range(1024, 2047); b = $urandom_range(2047);
      end
      if (!leaf_ready(a, b)) b = 0;
      send_link(n, 1'b1, a, b);
    end
  endtask

  task automatic send_filler(int lim);
    item_t it;
    int r, n;
    r = $urandom_range(9);
    n = $urandom_range(NUM_NODES - 1);
    if (r >= 6 && r < 9 && box_known[n]) begin
      send_read(n);
    end else if (r == 9 && lim < NUM_NODES) begin
      it = rand_item(MODE_LINK);
      it.idx = 11'($urandom_range(lim, NUM_NODES - 1));
      send_item(it);
    end else begin
      it = rand_item(MODE_CORNER);
      if ($urandom_range(3) != 0) begin
        it.idx = 11'($urandom_range(1) ? $urandom_range(63) : $urandom_range(1000, 1023));
        it.corner = 2'($urandom_range(2));
      end
      send_item(it);
    end
  endtask

  task automatic test_preload();
    for (int t = 0; t < NUM_TRIS; t++)
      if (t < 64 || t >= 1016)
        for (int c = 0; c < 3; c++) send_corner(t, c);
  endtask

  task automatic test_directed();
    item_t it;
    // out-of-range corner writes
    send_corner(1024, 0);
    send_corner(2047, 1);
    send_corner(5, 3);
    // special values in the last triangle
    it = rand_item(MODE_CORNER);
    it.idx = 1023; it.corner = 0;
    it.x = 32'h8000_0000; it.y = POS_INF; it.z = 32'h7FFF_FFFF;
    send_item(it);
    it.corner = 1;
    it.x = 32'h0000_0000; it.y = NEG_INF; it.z = 32'hFF7F_FFFF;
    send_item(it);
    it.corner = 2;
    it.x = 32'h7FC0_0000; it.y = 32'hFFFF_FFFF; it.z = 32'h0000_0001;
    send_item(it);
    write_node_count(12'd0);
    send_item(rand_item(MODE_REFIT));
    write_node_count(12'd3);
    send_link(0, 1'b0, 1, 2);
    send_link(1, 1'b1, 1020, 10);
    send_link(2, 1'b1, 5, 0);
    send_item(rand_item(MODE_REFIT));
    send_read(0);
    send_read(1);
    send_read(2);
    // children below the parent keep their stored boxes
    send_link(2, 1'b0, 0, 1);
    send_item(rand_item(MODE_REFIT));
    send_read(2);
    send_read(0);
    send_link(2047, 1'b1, 2047, 2047);
  endtask

  task automatic test_random(int quota);
    int lim, order[$], j;
    random_items = 0;
    while (random_items < quota) begin
      lim = $urandom_range(3) == 0 ? $urandom_range(1, 4) : $urandom_range(2, 40);
      write_node_count(12'(lim));
      repeat (2) begin
        order.delete();
        for (int n = 0; n < lim; n++) order.insert(order.size(), n);
        order.shuffle();
        foreach (order[k]) begin
          send_safe_link(order[k], lim);
          if ($urandom_range(1)) send_filler(lim);
        end
        send_item(rand_item(MODE_REFIT));
        repeat ($urandom_range(2, 6)) begin
          j = $urandom_range(lim - 1);
          send_read(j);
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_mode = MODE_CORNER; in_target_index = '0;
    in_corner = '0; in_coord_x = '0; in_coord_y = '0; in_coord_z = '0;
    in_is_leaf = 1'b0; in_link_a = '0; in_link_b = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    fail_count = 0; node_count_m = '0;
    for (int n = 0; n < NUM_NODES; n++) box_known[n] = 1'b0;
    for (int t = 0; t < NUM_TRIS; t++) corner_mask[t] = 3'b000;
    send_idle = 8; recv_stall = 78;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preload();
    test_directed();
    test_random(130);
    send_idle = 78; recv_stall = 8;
    test_random(130);
    send_idle = 0; recv_stall = 0;
    test_random(130);
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("bvh_bottom_up_refit_top: match");
    end else begin
      $display("bvh_bottom_up_refit_top: mismatch");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("bvh_bottom_up_refit_top: mismatch");
    $finish;
  end

endmodule
